@@ design/hrpe_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hrpe_pkg
// Shared types and constants for the histogram rebinning block.
// ============================================================================
package hrpe_pkg;

    localparam int SUM_W   = 42;
    localparam int PACK_W  = 11;
    localparam int FILL_W  = 10;
    localparam int IDX_W   = 20;
    localparam int CNT_W   = 21;
    localparam int MEAN_W  = 40;
    localparam int ERR_W   = 25;
    localparam int DVD_W   = SUM_W + 8;
    localparam int ROOT_W  = 24;
    localparam int RAD_W   = MEAN_W + 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [PACK_W-1:0] MAX_PACKING = PACK_W'(1024);
    localparam logic [ERR_W-1:0]  ERR_ONE     = ERR_W'(256);

    typedef enum logic [1:0] {
        REG_PACKING   = 2'd0,
        REG_FIT_FIRST = 2'd1,
        REG_FIT_LAST  = 2'd2
    } reg_idx_t;

    // one finished group on its way to the back end
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [PACK_W-1:0] pack;
        logic [IDX_W-1:0]  idx;
        logic              inwin;
        logic [CNT_W-1:0]  cnt;
    } job_t;

endpackage

@@ design/hrpe_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hrpe_front
// Accumulate raw bins into groups and hand each finished group to the queue.
// ============================================================================
module hrpe_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [31:0]                 raw_count,
    input  logic                        first_of_run,
    input  logic                        last_of_run,
    input  logic [hrpe_pkg::PACK_W-1:0] packing,
    input  logic [hrpe_pkg::IDX_W-1:0]  fit_first_bin,
    input  logic [hrpe_pkg::IDX_W-1:0]  fit_last_bin,
    input  logic                        q_full,
    output logic                        q_push,
    output hrpe_pkg::job_t              q_data
);
    import hrpe_pkg::*;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              active_reg, active_next;
    logic [PACK_W-1:0] eff_pack;
    logic              accept;
    logic              inwin;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign inwin  = (idx_reg >= fit_first_bin) && (idx_reg <= fit_last_bin);

    always_comb
    begin
        eff_pack = packing;
        if (packing == '0)
            eff_pack = PACK_W'(1);
        else if (packing > MAX_PACKING)
            eff_pack = MAX_PACKING;
    end

    always_comb
    begin
        sum_next    = sum_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        q_push      = 1'b0;
        q_data.sum   = sum_reg;
        q_data.pack  = eff_pack;
        q_data.idx   = idx_reg;
        q_data.inwin = inwin;
        q_data.cnt   = cnt_reg;
        if (inwin && cnt_reg != '1)
            q_data.cnt = cnt_reg + CNT_W'(1);
        if (accept)
        begin
            if (first_of_run)
            begin
                sum_next    = SUM_W'(raw_count);
                fill_next   = '0;
                idx_next    = '0;
                cnt_next    = '0;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if ({1'b0, fill_reg} + PACK_W'(1) >= eff_pack)
                begin
                    // close the group and start the next one with this bin
                    q_push    = 1'b1;
                    cnt_next  = q_data.cnt;
                    idx_next  = idx_reg + IDX_W'(1);
                    sum_next  = SUM_W'(raw_count);
                    fill_next = '0;
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(raw_count);
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            if (last_of_run && (first_of_run || active_reg))
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ design/hrpe_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hrpe_queue
// Small register queue of finished groups between front and back end.
// ============================================================================
module hrpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  hrpe_pkg::job_t wdata,
    output logic           q_full,
    input  logic           rd,
    output logic           q_valid,
    output hrpe_pkg::job_t rdata
);
    import hrpe_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign q_full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + QPTR_W'(1);
            if (rd)
                rp_reg <= rp_reg + QPTR_W'(1);
            if (wr && !rd)
                cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
            else if (rd && !wr)
                cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

@@ design/hrpe_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hrpe_back
// Divide the group sum by the packing, take the square root, register result.
// ============================================================================
module hrpe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  hrpe_pkg::job_t              q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [hrpe_pkg::MEAN_W-1:0] mean_value,
    output logic [hrpe_pkg::ERR_W-1:0]  error_value,
    output logic [hrpe_pkg::IDX_W-1:0]  bin_index,
    output logic                        in_window,
    output logic [20:0]                 fit_bin_count
);
    import hrpe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t            state_reg;
    job_t              job_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [PACK_W-1:0] drem_reg;
    logic [MEAN_W-1:0] quo_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [26:0]       srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0]        step_reg;
    logic              ovalid_reg;

    logic [PACK_W:0]   dshift;
    logic              dge;
    logic [26:0]       sshift, strial;
    logic              sge;
    logic              out_free;

    assign dshift   = {drem_reg, dvd_reg[DVD_W-1]};
    assign dge      = dshift >= {1'b0, job_reg.pack};
    assign sshift   = {srem_reg[24:0], rad_reg[RAD_W-1 -: 2]};
    assign strial   = {1'b0, root_reg, 2'b01};
    assign sge      = sshift >= strial;
    assign out_free = !ovalid_reg || pop;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign empty    = !ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            // load a new result, else drop the one just popped
            if ((state_reg == ST_DONE) && out_free)
                ovalid_reg <= 1'b1;
            else if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= 6'(DVD_W - 1);
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_SQRT;
                        step_reg  <= 6'(ROOT_W - 1);
                    end
                    else
                        step_reg <= step_reg - 6'd1;
                end
                ST_SQRT:
                begin
                    if (step_reg == '0)
                        state_reg <= ST_DONE;
                    else
                        step_reg <= step_reg - 6'd1;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath: restoring divide one quotient bit a cycle, then root one digit a cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= q_data;
                dvd_reg  <= {q_data.sum, 8'd0};
                drem_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                drem_reg <= dge ? PACK_W'(dshift - {1'b0, job_reg.pack}) : PACK_W'(dshift);
                quo_reg  <= {quo_reg[MEAN_W-2:0], dge};
                if (step_reg == '0)
                begin
                    rad_reg  <= {quo_reg[MEAN_W-2:0], dge, 8'd0};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            ST_SQRT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                srem_reg <= sge ? (sshift - strial) : sshift;
                root_reg <= {root_reg[ROOT_W-2:0], sge};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    mean_value    <= quo_reg;
                    error_value   <= (quo_reg == '0) ? ERR_ONE : ERR_W'(root_reg);
                    bin_index     <= job_reg.idx;
                    in_window     <= job_reg.inwin;
                    fit_bin_count <= job_reg.cnt;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/histogram_rebin_poisson_error.sv @@
`timescale 1ns / 1ps
// ============================================================================
// histogram_rebin_poisson_error
// Rebin raw histogram counts into packed bins with mean and Poisson error.
// ============================================================================
//  channel   handshake            payload
//  input     push / full          raw_count, first_of_run, last_of_run
//  result    empty / pop          mean_value, error_value, bin_index,
//                                 in_window, fit_bin_count
//  config    psel/penable/pwrite  paddr, pwdata, prdata (APB-style)
//
//  The front takes one raw bin a cycle while the queue has room.
//  Each finished group passes through the back end in order: load, the bit-serial
//  divide by packing, the digit-serial square root, then hand-off; a four-deep
//  queue absorbs bursts between the two.
//  Reset is asynchronous, active low; no clearing pass is needed.
//  A held result stalls the back end; the front keeps accepting until the queue fills.
// ============================================================================
module histogram_rebin_poisson_error (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [31:0]                 raw_count,
    input  logic                        first_of_run,
    input  logic                        last_of_run,
    output logic                        empty,
    input  logic                        pop,
    output logic [hrpe_pkg::MEAN_W-1:0] mean_value,
    output logic [hrpe_pkg::ERR_W-1:0]  error_value,
    output logic [hrpe_pkg::IDX_W-1:0]  bin_index,
    output logic                        in_window,
    output logic [20:0]                 fit_bin_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hrpe_pkg::*;

    logic [PACK_W-1:0] packing_reg;
    logic [IDX_W-1:0]  fit_first_reg;
    logic [IDX_W-1:0]  fit_last_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_sel;

    logic q_push, q_full, q_valid, q_pop;
    job_t q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    // config registers; a write beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packing_reg   <= PACK_W'(1);
            fit_first_reg <= '0;
            fit_last_reg  <= '1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_PACKING:   packing_reg   <= pwdata[PACK_W-1:0];
                REG_FIT_FIRST: fit_first_reg <= pwdata[IDX_W-1:0];
                REG_FIT_LAST:  fit_last_reg  <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_PACKING:   prdata = 32'(packing_reg);
            REG_FIT_FIRST: prdata = 32'(fit_first_reg);
            REG_FIT_LAST:  prdata = 32'(fit_last_reg);
            default:       prdata = '0;
        endcase
    end

    hrpe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .raw_count     (raw_count),
        .first_of_run  (first_of_run),
        .last_of_run   (last_of_run),
        .packing       (packing_reg),
        .fit_first_bin (fit_first_reg),
        .fit_last_bin  (fit_last_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    hrpe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_pop),
        .q_valid (q_valid),
        .rdata   (q_rdata)
    );

    hrpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .mean_value    (mean_value),
        .error_value   (error_value),
        .bin_index     (bin_index),
        .in_window     (in_window),
        .fit_bin_count (fit_bin_count)
    );

    // never write a request into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full)) else $error("queue overflow");

    // zero mean reports unit error
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && mean_value == '0) |-> (error_value == ERR_ONE))
        else $error("zero mean without unit error");

    // an in-window request has been counted
    a_win_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && in_window) |-> (fit_bin_count != '0))
        else $error("in-window request with zero count");

endmodule
